/* hdl/xsn_pkg.sv */
package xsn_pkg;

  localparam int DEF_BATCH_WORDS = 128;
  localparam int NIB_PER_WORD    = 16;
  localparam int SHL_A           = 23;
  localparam int SHR_A           = 17;
  localparam int SHR_B           = 26;
  localparam int SEED_SHR        = 30;
  localparam logic [30:0] SEED_MULT = 31'd1812433253;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    CMD_WORD   = 2'd0,
    CMD_NIBBLE = 2'd1,
    CMD_SEED   = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_SEED    = 1'b0,
    CFG_DISCARD = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_DISCARD,
    ST_REFILL,
    ST_POP,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] value;
  } gen_t;

  // one xorshift128+ advance
  function automatic gen_t xs_next(input logic [63:0] s0, input logic [63:0] s1);
    logic [63:0] a;
    gen_t g;
    a = s0 ^ (s0 << SHL_A);
    g.w0 = s1;
    g.w1 = a ^ s1 ^ (a >> SHR_A) ^ (s1 >> SHR_B);
    g.value = g.w1 + s1;
    return g;
  endfunction

endpackage

/* hdl/xsn_store.sv */
module xsn_store
  import xsn_pkg::*;
#(
  parameter int DEPTH = DEF_BATCH_WORDS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/xsn_seed_mul.sv */
module xsn_seed_mul
  import xsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] seed,
  output logic        done,
  output logic [63:0] result
);

  logic [3:0]  v_r;
  logic [63:0] x_r;
  logic [62:0] plo_r;
  logic [31:0] phi_r;
  logic [63:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  // 64x31 product split into two 32x31 halves, registered in turn (plo_r, then phi_r), then summed
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= seed ^ (seed >> SEED_SHR);
    end
    if (v_r[0]) begin
      plo_r <= x_r[31:0] * SEED_MULT;
    end
    if (v_r[1]) begin
      phi_r <= 32'(x_r[63:32] * SEED_MULT);
    end
    if (v_r[2]) begin
      res_r <= {1'b0, plo_r} + {phi_r, 32'b0} + 64'd1;
    end
  end

  assign done   = v_r[3];
  assign result = res_r;

endmodule

/* hdl/xorshift128plus_nibble_generator_core.sv */
// xorshift128+ random source with a last-in first-out nibble buffer.
// in channel: in_tuser carries the command, in_tdata the limit and load words.
// out channel: one 64-bit result per request (nibble in bits 3..0, or zero
// for reseed and load requests).
// cfg port: cfg_index 0 writes the seed, 1 writes the discard count; write
// only while no request is in flight.
// sequence: word and load requests finish in the accept cycle (result visible
// the next cycle), one request per cycle while the output is not stalled. a
// nibble request reads the buffer memory and then compares the nibble with the
// limit, pops again for each rejected nibble, and refills the buffer memory
// with BATCH_WORDS words whenever it runs empty. a reseed runs the seed through
// the split multiplier, then advances the generator once per discarded output.
// reset: state words go to 0 and 1, the buffer is marked empty, config
// registers clear. buffer memory contents are not cleared.
// stall: a finished result waits in the output register; in_tready stays low
// until that register is free or taken in the same cycle.
module xorshift128plus_nibble_generator_core
  import xsn_pkg::*;
#(
  parameter int BATCH_WORDS = DEF_BATCH_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command [1:0]
  input  logic [1:0]            in_tuser,
  // nibble_limit [3:0], load_word0 [67:4], load_word1 [131:68], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // random_value [63:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_data
);

  localparam int AW      = (BATCH_WORDS > 1) ? $clog2(BATCH_WORDS) : 1;
  localparam int NL_W    = $clog2(BATCH_WORDS * NIB_PER_WORD + 1);
  localparam logic [NL_W-1:0] NL_FULL   = NL_W'(BATCH_WORDS * NIB_PER_WORD);
  localparam logic [AW-1:0]   FILL_LAST = AW'(BATCH_WORDS - 1);

  state_t state_r, state_nxt;

  logic [63:0]     w0_r, w0_nxt;
  logic [63:0]     w1_r, w1_nxt;
  logic [NL_W-1:0] nl_r, nl_nxt;
  logic [AW-1:0]   fill_r, fill_nxt;
  logic [15:0]     disc_r, disc_nxt;
  logic [3:0]      limit_r, limit_nxt;
  logic [3:0]      shift_r, shift_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_data_r, out_data_nxt;
  logic [63:0]     seed_r;
  logic [15:0]     disc_cnt_r;

  logic            in_acc;
  cmd_t            cmd;
  gen_t            step;
  logic [NL_W-1:0] pos;
  logic            finish;
  logic [63:0]     finish_data;

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [63:0]     mem_rdata;
  logic [3:0]      nib;
  logic            nib_ok;

  logic            mul_start;
  logic            mul_done;
  logic [63:0]     mul_result;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign step      = xs_next(w0_r, w1_r);
  assign pos       = nl_r - 1'b1;
  assign nib       = mem_rdata[{shift_r, 2'b00} +: 4];
  assign nib_ok    = (nib <= limit_r);
  assign mul_start = in_acc && (cmd == CMD_SEED);

  xsn_store #(
    .DEPTH (BATCH_WORDS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_r),
    .wdata (step.value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  xsn_seed_mul u_seed_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .seed   (seed_r),
    .done   (mul_done),
    .result (mul_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_NIBBLE: state_nxt = (nl_r == '0) ? ST_REFILL : ST_CHECK;
            CMD_SEED:   state_nxt = ST_SEED;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          state_nxt = (disc_cnt_r == '0) ? ST_IDLE : ST_DISCARD;
        end
      end
      ST_DISCARD: begin
        if (disc_r == 16'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REFILL: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (nib_ok) begin
          state_nxt = ST_IDLE;
        end else if (nl_r == '0) begin
          state_nxt = ST_REFILL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    w0_nxt      = w0_r;
    w1_nxt      = w1_r;
    nl_nxt      = nl_r;
    fill_nxt    = fill_r;
    disc_nxt    = disc_r;
    limit_nxt   = limit_r;
    shift_nxt   = shift_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = pos[AW+3:4];
    finish      = 1'b0;
    finish_data = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          limit_nxt = in_tdata[3:0];
          case (cmd)
            CMD_WORD: begin
              w0_nxt      = step.w0;
              w1_nxt      = step.w1;
              finish      = 1'b1;
              finish_data = step.value;
            end
            CMD_NIBBLE: begin
              if (nl_r != '0) begin
                mem_re    = 1'b1;
                nl_nxt    = pos;
                shift_nxt = pos[3:0];
              end
            end
            CMD_SEED: begin
              w0_nxt = seed_r;
            end
            default: begin
              w0_nxt = in_tdata[67:4];
              w1_nxt = in_tdata[131:68];
              nl_nxt = '0;
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          w1_nxt   = mul_result;
          disc_nxt = disc_cnt_r;
          finish   = (disc_cnt_r == '0);
        end
      end
      ST_DISCARD: begin
        w0_nxt   = step.w0;
        w1_nxt   = step.w1;
        disc_nxt = disc_r - 16'd1;
        finish   = (disc_r == 16'd1);
      end
      ST_REFILL: begin
        mem_we   = 1'b1;
        w0_nxt   = step.w0;
        w1_nxt   = step.w1;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == FILL_LAST) begin
          fill_nxt = '0;
          nl_nxt   = NL_FULL;
        end
      end
      ST_POP: begin
        mem_re    = 1'b1;
        nl_nxt    = pos;
        shift_nxt = pos[3:0];
      end
      ST_CHECK: begin
        if (nib_ok) begin
          finish      = 1'b1;
          finish_data = {60'b0, nib};
        end else if (nl_r != '0) begin
          // rejected, pop the next one
          mem_re    = 1'b1;
          nl_nxt    = pos;
          shift_nxt = pos[3:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = finish_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      w0_r        <= 64'd0;
      w1_r        <= 64'd1;
      nl_r        <= '0;
      fill_r      <= '0;
      disc_r      <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      disc_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      w0_r        <= w0_nxt;
      w1_r        <= w1_nxt;
      nl_r        <= nl_nxt;
      fill_r      <= fill_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEED:    seed_r     <= cfg_data;
          CFG_DISCARD: disc_cnt_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    shift_r    <= shift_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || out_tready))
    else $error("result written over a pending result");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_WORD || cmd == CMD_LOAD)) |=> out_valid_r)
    else $error("word or load request gave no result");

  a_pop_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (nl_r == NL_FULL))
    else $error("first pop without a full buffer");

  a_check_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (nl_r < NL_FULL))
    else $error("compare without a preceding pop");

  a_load_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_LOAD) |=> (nl_r == '0))
    else $error("load did not empty the buffer");

endmodule
